@@ sv/stn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stn_pkg
// Shared types and codes of the sorted top-N score table.
// ----------------------------------------------------------------------------
package stn_pkg;

  // Action codes of a request
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // Request payload
  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        score;
    logic [15:0]        top_speed;
    logic signed [15:0] obstacle_stat;
    logic signed [15:0] speed_stat;
    logic signed [15:0] bonus_stat;
    logic [15:0]        player_id;
    logic [2:0]         read_index;
  } req_t;

  // Result payload
  typedef struct packed {
    logic [3:0]         rank;
    logic               slot_used;
    logic [31:0]        slot_score;
    logic [15:0]        slot_speed;
    logic signed [15:0] slot_obstacles;
    logic signed [15:0] slot_speed_stat;
    logic signed [15:0] slot_bonus_stat;
    logic [15:0]        slot_player;
  } res_t;

  // One stored table entry
  typedef struct packed {
    logic [31:0]        score;
    logic [15:0]        speed;
    logic signed [15:0] obstacles;
    logic signed [15:0] speed_stat;
    logic signed [15:0] bonus_stat;
    logic [15:0]        player;
  } rec_t;

endpackage

@@ sv/stn_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stn_mem
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stn_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  stn_pkg::rec_t       wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output stn_pkg::rec_t       rd_data
);

  stn_pkg::rec_t mem [DEPTH];

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read data; hold it while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/sorted_top_n_score_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_top_n_score_table
// Table of the best TABLE_DEPTH records, kept sorted by descending score.
//
//   channel  signals                     direction
//   request  req_valid, req_stall, req   into the block
//   result   res_valid, res_stall, res   out of the block
//
// One request is worked at a time. An insert compares and moves one slot
// per cycle from the last slot upward, then writes the new record at its place;
// a record that cannot beat the last slot of a full table is discarded.
// Reset empties the table at once; written flags make a never-written slot read 0.
// A stalled result holds; the next request is still taken, its result waits.
// ----------------------------------------------------------------------------
module sorted_top_n_score_table #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  stn_pkg::req_t  req,
  output logic           res_valid,
  input  logic           res_stall,
  output stn_pkg::res_t  res
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(TABLE_DEPTH - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SHIFT = 3'd1;
  localparam logic [2:0] ST_PLACE = 3'd2;
  localparam logic [2:0] ST_RDOUT = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]             state;
  stn_pkg::req_t          cmd;
  logic [CW-1:0]          dest;
  logic [CW-1:0]          fill;
  logic [TABLE_DEPTH-1:0] written;

  logic                   accept;
  logic                   res_free;
  logic                   res_load;
  stn_pkg::res_t          res_next;
  logic [CW-1:0]          src;
  logic [CW-1:0]          src_m1;
  logic                   dest_in;
  logic                   moves;
  logic                   idx_in;
  logic [AW-1:0]          idx_a;
  stn_pkg::rec_t          new_rec;

  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  stn_pkg::rec_t          wr_data;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  stn_pkg::rec_t          rd_data;

  stn_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Handshake
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign res_free  = !res_valid || !res_stall;

  // Walk pointers: slot src is compared, and moves into dest if it must
  assign src     = dest - CW'(1);
  assign src_m1  = src - CW'(1);
  assign dest_in = (dest != DEPTH_C);
  assign moves   = (src >= fill) || (rd_data.score < cmd.score);

  // Read slot of a read request
  assign idx_in = ({29'd0, cmd.read_index} < 32'(TABLE_DEPTH));
  assign idx_a  = AW'(cmd.read_index);

  always_comb begin
    new_rec.score      = cmd.score;
    new_rec.speed      = cmd.top_speed;
    new_rec.obstacles  = cmd.obstacle_stat;
    new_rec.speed_stat = cmd.speed_stat;
    new_rec.bonus_stat = cmd.bonus_stat;
    new_rec.player     = cmd.player_id;
  end

  // Memory read: last slot to start an insert, the slot of a read,
  // then the next slot up while entries keep moving down
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (state == ST_IDLE && accept) begin
      if (req.action == stn_pkg::ACT_INSERT) begin
        rd_en   = 1'b1;
        rd_addr = LAST_A;
      end else if (req.action == stn_pkg::ACT_READ) begin
        rd_en   = 1'b1;
        rd_addr = AW'(req.read_index);
      end
    end else if (state == ST_SHIFT && moves && src != '0) begin
      rd_en   = 1'b1;
      rd_addr = src_m1[AW-1:0];
    end
  end

  // Memory write: moved entry, or the new record at its place
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = dest[AW-1:0];
    wr_data = rd_data;
    if (state == ST_SHIFT) begin
      wr_en = moves && dest_in;
    end else if (state == ST_PLACE) begin
      wr_en   = res_free && dest_in;
      wr_data = new_rec;
    end
  end

  // Result to load into the output register
  always_comb begin
    res_load = 1'b0;
    res_next = '0;
    case (state)
      ST_PLACE: begin
        res_load      = res_free;
        res_next.rank = 4'(dest);
      end
      ST_RDOUT: begin
        res_load = res_free;
        if (idx_in) begin
          res_next.slot_used = ({29'd0, cmd.read_index} < 32'(fill));
          if (written[idx_a]) begin
            res_next.slot_score      = rd_data.score;
            res_next.slot_speed      = rd_data.speed;
            res_next.slot_obstacles  = rd_data.obstacles;
            res_next.slot_speed_stat = rd_data.speed_stat;
            res_next.slot_bonus_stat = rd_data.bonus_stat;
            res_next.slot_player     = rd_data.player;
          end
        end
      end
      ST_FIN: begin
        res_load = res_free;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // Control: sequencer, fill count, written flags, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      dest      <= '0;
      fill      <= '0;
      written   <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (req.action)
              stn_pkg::ACT_INSERT: begin
                dest  <= DEPTH_C;
                state <= ST_SHIFT;
              end
              stn_pkg::ACT_READ: begin
                state <= ST_RDOUT;
              end
              stn_pkg::ACT_CLEAR: begin
                fill  <= '0;
                state <= ST_FIN;
              end
              default: begin
                state <= ST_FIN;
              end
            endcase
          end
        end
        ST_SHIFT: begin
          if (moves) begin
            if (dest_in) begin
              written[dest[AW-1:0]] <= written[src[AW-1:0]];
            end
            dest <= src;
            if (src == '0) begin
              state <= ST_PLACE;
            end
          end else begin
            state <= ST_PLACE;
          end
        end
        ST_PLACE: begin
          if (res_free) begin
            if (dest_in) begin
              written[dest[AW-1:0]] <= 1'b1;
              if (fill != DEPTH_C) begin
                fill <= fill + CW'(1);
              end
            end
            state <= ST_IDLE;
          end
        end
        ST_RDOUT, ST_FIN: begin
          if (res_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload: latched request and output register
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= req;
    end
    if (res_load) begin
      res <= res_next;
    end
  end

endmodule

@@ sv/stn_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stn_checker
// Port-level checks of the sorted top-N score table, bound to the top level.
// ----------------------------------------------------------------------------
module stn_checker #(
  parameter int TABLE_DEPTH = 8
) (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          res_valid,
  input logic          res_stall,
  input stn_pkg::res_t res
);

  // Hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // Work one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while busy");

  // Rank never passes the table depth
  a_rank_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (TABLE_DEPTH > 15) || (res.rank <= 4'(TABLE_DEPTH)))
    else $error("rank out of range");

  // A read result carries no rank
  a_read_rank: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.slot_used |-> res.rank == 4'd0)
    else $error("read result with rank");

endmodule

bind sorted_top_n_score_table stn_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_stn_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted top-N score table. A queue of directed
// and random requests feeds a valid/stall driver. A monitor keeps its own
// copy of the table, predicts each result when its request is accepted, and
// checks every result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import stn_pkg::*;

  localparam int         DEPTH      = 8;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int         N_RANDOM   = 1250;
  localparam int         CYCLE_CAP  = 200000;
  localparam int         LONG_HOLD  = 150;

  typedef struct {
    req_t r;
    bit   drain;
  } pend_t;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  pend_t pending[$];
  res_t  predicted[$];
  int    n_total   = 0;
  int    n_req     = 0;
  int    n_errors  = 0;
  int    cycles    = 0;
  bit    quiet     = 1'b1;

  // Bench copy of the table
  bit   tbl_used[DEPTH];
  rec_t tbl_rec[DEPTH];

  sorted_top_n_score_table #(.TABLE_DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idling is off in the last part of the run and in every third stretch
  function automatic bit idle_on();
    return (n_req < n_total - 200) && ((n_req / 150) % 3 != 2);
  endfunction

  // Apply one request to the bench table and return the result it yields
  function automatic res_t score_table_apply(input req_t r);
    res_t o;
    rec_t fresh;
    int   pos;
    o = '0;
    case (r.action)
      ACT_INSERT: begin
        pos = 0;
        while (pos < DEPTH && tbl_used[pos] && !(tbl_rec[pos].score < r.score))
          pos++;
        if (pos < DEPTH) begin
          for (int k = DEPTH - 1; k > pos; k--) begin
            tbl_used[k] = tbl_used[k-1];
            tbl_rec[k]  = tbl_rec[k-1];
          end
          fresh.score      = r.score;
          fresh.speed      = r.top_speed;
          fresh.obstacles  = r.obstacle_stat;
          fresh.speed_stat = r.speed_stat;
          fresh.bonus_stat = r.bonus_stat;
          fresh.player     = r.player_id;
          tbl_used[pos]    = 1'b1;
          tbl_rec[pos]     = fresh;
        end
        o.rank = 4'(pos);
      end
      ACT_READ: begin
        if (int'(r.read_index) < DEPTH) begin
          o.slot_used       = tbl_used[r.read_index];
          o.slot_score      = tbl_rec[r.read_index].score;
          o.slot_speed      = tbl_rec[r.read_index].speed;
          o.slot_obstacles  = tbl_rec[r.read_index].obstacles;
          o.slot_speed_stat = tbl_rec[r.read_index].speed_stat;
          o.slot_bonus_stat = tbl_rec[r.read_index].bonus_stat;
          o.slot_player     = tbl_rec[r.read_index].player;
        end
      end
      ACT_CLEAR: begin
        for (int k = 0; k < DEPTH; k++) tbl_used[k] = 1'b0;
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  function automatic req_t make_insert(input logic [31:0] score,
                                       input logic [15:0] speed,
                                       input logic [15:0] obs,
                                       input logic [15:0] spd,
                                       input logic [15:0] bonus,
                                       input logic [15:0] player);
    req_t r;
    r               = '0;
    r.action        = ACT_INSERT;
    r.score         = score;
    r.top_speed     = speed;
    r.obstacle_stat = obs;
    r.speed_stat    = spd;
    r.bonus_stat    = bonus;
    r.player_id     = player;
    return r;
  endfunction

  function automatic req_t make_read(input logic [2:0] idx);
    req_t r;
    r            = '0;
    r.action     = ACT_READ;
    r.read_index = idx;
    return r;
  endfunction

  // Random request: ties and full-table discards are frequent on purpose
  function automatic req_t random_request();
    req_t r;
    int   sel;
    r.action        = ACT_UNUSED;
    r.score         = $urandom;
    r.top_speed     = 16'($urandom);
    r.obstacle_stat = 16'($urandom);
    r.speed_stat    = 16'($urandom);
    r.bonus_stat    = 16'($urandom);
    r.player_id     = 16'($urandom);
    r.read_index    = 3'($urandom_range(0, 7));
    sel = $urandom_range(0, 99);
    if (sel < 58)      r.action = ACT_INSERT;
    else if (sel < 92) r.action = ACT_READ;
    else if (sel < 96) r.action = ACT_CLEAR;
    sel = $urandom_range(0, 99);
    if (sel < 35)      r.score = 32'($urandom_range(0, 15));
    else if (sel < 45) r.score = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    else if (sel < 60) r.score = 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
    return r;
  endfunction

  function automatic void queue_request(input req_t r, input bit drain);
    pend_t p;
    p.r     = r;
    p.drain = drain;
    pending.push_back(p);
  endfunction

  // Stimulus, reset and end of run
  initial begin
    req_t r;
    // read an empty table
    queue_request(make_read(3'd0), 1'b0);
    // extremes of every field, ties at both ends of the score range
    queue_request(make_insert(32'h0, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF), 1'b0);
    queue_request(make_insert(32'hFFFF_FFFF, 16'h0, 16'h7FFF, 16'h8000, 16'h0, 16'h0), 1'b0);
    queue_request(make_insert(32'hFFFF_FFFF, 16'h1, 16'h1, 16'h1, 16'h1, 16'h1), 1'b0);
    queue_request(make_insert(32'h0, 16'h2, 16'h2, 16'h2, 16'h2, 16'h2), 1'b0);
    // fill the table, then offer a record that ties the last slot
    queue_request(make_insert(32'd100, 16'h3, 16'h3, 16'h3, 16'h3, 16'h3), 1'b0);
    queue_request(make_insert(32'd200, 16'h4, 16'h4, 16'h4, 16'h4, 16'h4), 1'b0);
    queue_request(make_insert(32'd300, 16'h5, 16'h5, 16'h5, 16'h5, 16'h5), 1'b0);
    queue_request(make_insert(32'd400, 16'h6, 16'h6, 16'h6, 16'h6, 16'h6), 1'b0);
    queue_request(make_insert(32'h0, 16'h7, 16'h7, 16'h7, 16'h7, 16'h7), 1'b0);
    // push out the last slot
    queue_request(make_insert(32'd50, 16'h8, 16'h8, 16'h8, 16'h8, 16'h8), 1'b0);
    queue_request(make_read(3'd7), 1'b0);
    queue_request(make_read(3'd6), 1'b0);
    // clear keeps stored data, only the used flags drop
    r        = '0;
    r.action = ACT_CLEAR;
    queue_request(r, 1'b0);
    queue_request(make_read(3'd2), 1'b0);
    // unused action code with every payload bit set
    r        = '1;
    r.action = ACT_UNUSED;
    queue_request(r, 1'b0);
    queue_request(make_read(3'd5), 1'b0);
    queue_request(make_insert(32'd5, 16'h9, 16'h9, 16'h9, 16'h9, 16'h9), 1'b0);
    queue_request(make_read(3'd0), 1'b0);
    queue_request(make_read(3'd1), 1'b0);
    // random part: drain once after the directed part and once midway
    for (int i = 0; i < N_RANDOM; i++)
      queue_request(random_request(), (i == 0) || (i == 650));
    n_total = pending.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (pending.size() != 0 || req_valid || !quiet);
    repeat (40) @(posedge clk);
    if (n_errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Drive requests from the pending queue
  int gap_left = 0;
  always @(posedge clk) begin
    logic nxt_valid;
    req_t nxt_req;
    if (rst) begin
      req_valid <= 1'b0;
      req       <= '0;
    end else begin
      nxt_valid = req_valid;
      nxt_req   = req;
      if (req_valid && !req_stall) nxt_valid = 1'b0;
      if (!nxt_valid && pending.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending[0].drain && !(quiet && !req_valid)) begin
          // hold until every outstanding result has come back
        end else if (idle_on() && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(0, 3);
        end else begin
          nxt_req   = pending.pop_front().r;
          nxt_valid = 1'b1;
        end
      end
      req_valid <= nxt_valid;
      req       <= nxt_req;
    end
  end

  // Stall the result channel: random bursts plus one long hold-off
  int  hold_left  = 0;
  int  burst_left = 0;
  bit  long_done  = 1'b0;
  always @(posedge clk) begin
    logic nxt_stall;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (!long_done && n_req >= 350) begin
        long_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      nxt_stall = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
        nxt_stall = 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        nxt_stall = 1'b1;
      end else if (idle_on() && $urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(0, 3);
        nxt_stall  = 1'b1;
      end
      res_stall <= nxt_stall;
    end
  end

  // Check results, then predict the result of any request taken this edge
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) begin
        tbl_used[k] = 1'b0;
        tbl_rec[k]  = '0;
      end
      quiet <= 1'b1;
      n_req <= 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (predicted.size() == 0) begin
          $error("unexpected result %h", res);
          n_errors++;
        end else begin
          want = predicted.pop_front();
          check_field("rank", want.rank, res.rank);
          check_field("slot_used", want.slot_used, res.slot_used);
          check_field("slot_score", want.slot_score, res.slot_score);
          check_field("slot_speed", want.slot_speed, res.slot_speed);
          check_field("slot_obstacles", want.slot_obstacles, res.slot_obstacles);
          check_field("slot_speed_stat", want.slot_speed_stat, res.slot_speed_stat);
          check_field("slot_bonus_stat", want.slot_bonus_stat, res.slot_bonus_stat);
          check_field("slot_player", want.slot_player, res.slot_player);
        end
      end
      if (req_valid && !req_stall) begin
        predicted.push_back(score_table_apply(req));
        n_req <= n_req + 1;
      end
      quiet <= (predicted.size() == 0);
    end
  end

  // Cap the run length
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
